// ===== rtl/core/remote_dimmer_frame_encoder_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the radio dimmer frame encoder core
// Shared property forms; clk and rst_n come from the module that uses them.
// ----------------------------------------------------------------------------
`ifndef REMOTE_DIMMER_FRAME_ENCODER_CORE_MACROS_SVH
`define REMOTE_DIMMER_FRAME_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RDFE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rdfe: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define RDFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rdfe: next-cycle check failed");

`endif

// ===== rtl/core/rdfe_pkg.sv =====
// ----------------------------------------------------------------------------
// rdfe_pkg
// Shared types, frame byte codes and the level quantizer.
// ----------------------------------------------------------------------------
package rdfe_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned FRAME_BITS  = 24;  // 14 address, 2 parity, 6 command, 2 parity
  localparam int unsigned START_LEN   = 8;

  localparam logic [7:0] SYM_S    = 8'd83;
  localparam logic [7:0] SYM_T    = 8'd84;
  localparam logic [7:0] SYM_MARK = 8'd170;
  localparam logic [7:0] SYM_PLUS = 8'd43;

  localparam logic [1:0] CFG_SYSTEM_CODE = 2'd0;
  localparam logic [1:0] CFG_UNIT_MASK   = 2'd1;
  localparam logic [1:0] CFG_SMOOTH_FADE = 2'd2;

  localparam logic [7:0] LEVEL_OFF_MAX = 8'd12;
  localparam logic [7:0] LEVEL_DIM_MAX = 8'd237;
  localparam logic [3:0] CODE_OFF      = 4'd10;
  localparam logic [3:0] CODE_FULL     = 4'd0;

  typedef logic [FRAME_BITS-1:0] frame_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_BITS  = 4'b0100,
    ST_PLUS  = 4'b1000
  } bk_state_t;

  // 13..237 map to 1..9 in steps of 25: count the step thresholds passed.
  function automatic logic [3:0] level_code(input logic [7:0] lv);
    logic [3:0] code;
    code = 4'd1;
    for (int k = 0; k < 8; k++) begin
      if (lv >= 8'(38 + 25 * k)) code = code + 4'd1;
    end
    if (lv <= LEVEL_OFF_MAX) code = CODE_OFF;
    else if (lv > LEVEL_DIM_MAX) code = CODE_FULL;
    return code;
  endfunction

endpackage

// ===== rtl/core/rdfe_front.sv =====
// ----------------------------------------------------------------------------
// rdfe_front
// Holds the set-up registers and turns a level request into a 24-bit frame word.
// ----------------------------------------------------------------------------
module rdfe_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [1:0]            cfg_index,
  input  logic [9:0]            cfg_data,
  input  logic                  in_valid,
  input  logic [7:0]            in_level,
  input  rdfe_pkg::q_stat_t     q_stat,
  output logic                  in_stall,
  output logic                  push,
  output rdfe_pkg::frame_word_t push_word
);

  logic [3:0] system_code_r;
  logic [9:0] unit_mask_r;
  logic       smooth_fade_r;
  logic [13:0] addr;
  logic [5:0]  cmd;
  logic [5:0]  cmd_rev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      system_code_r <= '0;
      unit_mask_r   <= '0;
      smooth_fade_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rdfe_pkg::CFG_SYSTEM_CODE: system_code_r <= cfg_data[3:0];
        rdfe_pkg::CFG_UNIT_MASK:   unit_mask_r   <= cfg_data;
        rdfe_pkg::CFG_SMOOTH_FADE: smooth_fade_r <= cfg_data[0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  assign addr = {system_code_r, unit_mask_r};
  assign cmd  = {smooth_fade_r, 1'b1, rdfe_pkg::level_code(in_level)};

  // command bits go out least significant first
  always_comb begin
    for (int i = 0; i < 6; i++) cmd_rev[5-i] = cmd[i];
  end

  // parity bit 1 (T,T) when the group holds an even number of ones
  assign push_word = {
    addr,
    ~^{addr[13], addr[11], addr[9], addr[7], addr[5], addr[3], addr[1]},
    ~^{addr[12], addr[10], addr[8], addr[6], addr[4], addr[2], addr[0]},
    cmd_rev,
    ~^{cmd[4], cmd[2], cmd[0]},
    ~^{cmd[5], cmd[3], cmd[1]}
  };

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

endmodule

// ===== rtl/core/rdfe_queue.sv =====
// ----------------------------------------------------------------------------
// rdfe_queue
// Short FIFO of frame words between the request side and the serializer.
// ----------------------------------------------------------------------------
module rdfe_queue #(
  parameter int unsigned DEPTH = rdfe_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  rdfe_pkg::frame_word_t push_word,
  input  logic                  pop,
  output rdfe_pkg::frame_word_t pop_word,
  output rdfe_pkg::q_stat_t     q_stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rdfe_pkg::frame_word_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_word;
  end

  assign pop_word     = mem_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CNT_W'(DEPTH));
  assign q_stat.empty = (count_r == '0);

endmodule

// ===== rtl/core/rdfe_back.sv =====
// ----------------------------------------------------------------------------
// rdfe_back
// Frame serializer: one frame byte per cycle into a registered output stage, unless out_stall holds it.
// ----------------------------------------------------------------------------
module rdfe_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rdfe_pkg::q_stat_t     q_stat,
  input  rdfe_pkg::frame_word_t pop_word,
  output logic                  pop,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic [7:0]            out_symbol,
  output logic                  out_last
);

  localparam int unsigned POS_W = $clog2(rdfe_pkg::FRAME_BITS);
  localparam int unsigned CNT_W = $clog2(rdfe_pkg::START_LEN);

  rdfe_pkg::bk_state_t   state_r, state_nxt;
  rdfe_pkg::frame_word_t word_r, word_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  half_r, half_nxt;
  logic                  valid_r, valid_nxt;
  logic [7:0]            symbol_r, symbol_nxt;
  logic                  last_r, last_nxt;
  logic                  advance;
  logic                  cur_bit;

  assign advance = !valid_r || !out_stall;
  assign cur_bit = word_r[rdfe_pkg::FRAME_BITS-1];

  always_comb begin
    state_nxt  = state_r;
    word_nxt   = word_r;
    pos_nxt    = pos_r;
    cnt_nxt    = cnt_r;
    half_nxt   = half_r;
    valid_nxt  = valid_r;
    symbol_nxt = symbol_r;
    last_nxt   = last_r;
    pop        = 1'b0;
    if (advance) begin
      valid_nxt = 1'b1;
      last_nxt  = 1'b0;
      unique case (state_r)
        rdfe_pkg::ST_IDLE: begin
          if (q_stat.empty) begin
            valid_nxt = 1'b0;
          end else begin
            pop        = 1'b1;
            word_nxt   = pop_word;
            symbol_nxt = rdfe_pkg::SYM_S;
            cnt_nxt    = CNT_W'(1);
            state_nxt  = rdfe_pkg::ST_START;
          end
        end
        rdfe_pkg::ST_START: begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(rdfe_pkg::START_LEN - 1)) begin
            symbol_nxt = rdfe_pkg::SYM_MARK;
            pos_nxt    = '0;
            half_nxt   = 1'b0;
            state_nxt  = rdfe_pkg::ST_BITS;
          end else begin
            symbol_nxt = rdfe_pkg::SYM_T;
          end
        end
        rdfe_pkg::ST_BITS: begin
          if (cur_bit && !half_r) begin
            // a one is T,T: hold the bit for its second byte
            symbol_nxt = rdfe_pkg::SYM_T;
            half_nxt   = 1'b1;
          end else begin
            symbol_nxt = cur_bit ? rdfe_pkg::SYM_T : rdfe_pkg::SYM_MARK;
            half_nxt   = 1'b0;
            word_nxt   = {word_r[rdfe_pkg::FRAME_BITS-2:0], 1'b0};
            pos_nxt    = pos_r + 1'b1;
            if (pos_r == POS_W'(rdfe_pkg::FRAME_BITS - 1)) state_nxt = rdfe_pkg::ST_PLUS;
          end
        end
        rdfe_pkg::ST_PLUS: begin
          symbol_nxt = rdfe_pkg::SYM_PLUS;
          last_nxt   = 1'b1;
          state_nxt  = rdfe_pkg::ST_IDLE;
        end
        default: begin
          valid_nxt = 1'b0;
          state_nxt = rdfe_pkg::ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rdfe_pkg::ST_IDLE;
      pos_r   <= '0;
      cnt_r   <= '0;
      half_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      half_r  <= half_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r   <= word_nxt;
    symbol_r <= symbol_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid  = valid_r;
  assign out_symbol = symbol_r;
  assign out_last   = last_r;

endmodule

// ===== rtl/core/remote_dimmer_frame_encoder_core.sv =====
// ----------------------------------------------------------------------------
// remote_dimmer_frame_encoder_core
// Level request in, pulse-code frame bytes for a radio dimmer out.
// ----------------------------------------------------------------------------
//   channel | ports                               | flow
//   --------+-------------------------------------+-----------------------
//   in      | in_valid, in_stall, in_level        | one level request
//   out     | out_valid, out_stall, out_symbol,   | 33 to 57 frame bytes
//           | out_last                            | per request
//   cfg     | cfg_valid, cfg_ready, cfg_index,    | register write, always
//           | cfg_data                            | ready
//
// The serializer emits the frame bytes of a request one byte per cycle while
// out_stall is low. When it is free, the first byte shows once the request has
// passed the queue and the output register. Requests queue up to QUEUE_DEPTH
// ahead of the serializer; in_stall rises only when that queue is full.
// Reset (rst_n low, synchronous) clears registers, queue and serializer.
// out_stall holds the output register and serializer in place while out_valid is high.
// ----------------------------------------------------------------------------
`include "remote_dimmer_frame_encoder_core_macros.svh"

module remote_dimmer_frame_encoder_core #(
  parameter int unsigned QUEUE_DEPTH = rdfe_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_symbol,
  output logic       out_last
);

  rdfe_pkg::q_stat_t     q_stat;
  rdfe_pkg::frame_word_t push_word;
  rdfe_pkg::frame_word_t pop_word;
  logic                  push;
  logic                  pop;
  logic                  frame_done;
  logic                  sym_is_start;

  assign cfg_ready = 1'b1;

  rdfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_level  (in_level),
    .q_stat    (q_stat),
    .in_stall  (in_stall),
    .push      (push),
    .push_word (push_word)
  );

  rdfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .q_stat    (q_stat)
  );

  rdfe_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop_word   (pop_word),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_symbol (out_symbol),
    .out_last   (out_last)
  );

  assign frame_done   = out_valid && !out_stall && out_last;
  assign sym_is_start = out_valid && (out_symbol == rdfe_pkg::SYM_S);

  `RDFE_ASSERT_NOW(a_last_is_plus, out_valid, out_last == (out_symbol == rdfe_pkg::SYM_PLUS))
  `RDFE_ASSERT_NEXT(a_idle_after_frame, frame_done && q_stat.empty, !out_valid)
  `RDFE_ASSERT_NEXT(a_next_frame_starts, frame_done && !q_stat.empty, sym_is_start)

endmodule
